// File: hdl/i2p_pkg.sv
package i2p_pkg;

    typedef logic [7:0] char_t;
    typedef logic [1:0] prec_t;
    typedef logic [1:0] err_t;
    typedef logic [1:0] stk_op_t;

    localparam char_t CH_MUL    = 8'h2A;
    localparam char_t CH_DIV    = 8'h2F;
    localparam char_t CH_MOD    = 8'h25;
    localparam char_t CH_ADD    = 8'h2B;
    localparam char_t CH_SUB    = 8'h2D;
    localparam char_t CH_LPAREN = 8'h28;
    localparam char_t CH_RPAREN = 8'h29;

    localparam err_t ERR_NONE     = 2'd0;
    localparam err_t ERR_OVERFLOW = 2'd1;
    localparam err_t ERR_UNMATCH  = 2'd2;

    localparam stk_op_t STK_HOLD = 2'd0;
    localparam stk_op_t STK_PUSH = 2'd1;
    localparam stk_op_t STK_POP  = 2'd2;

    // Only operators and '(' ever sit on the stack.
    function automatic prec_t prec_of(char_t c);
        prec_t p;
        p = 2'd0;
        if (c == CH_MUL || c == CH_DIV || c == CH_MOD)
        begin
            p = 2'd2;
        end
        else if (c == CH_ADD || c == CH_SUB)
        begin
            p = 2'd1;
        end
        return p;
    endfunction

endpackage

// File: hdl/i2p_cell.sv
module i2p_cell (
    input  logic               clk,
    input  i2p_pkg::stk_op_t   op,
    input  i2p_pkg::char_t     from_above,
    input  i2p_pkg::char_t     from_below,
    output i2p_pkg::char_t     data
);

    i2p_pkg::char_t data_reg;
    i2p_pkg::char_t data_next;

    always_comb
    begin
        case (op)
            i2p_pkg::STK_PUSH: data_next = from_above;
            i2p_pkg::STK_POP:  data_next = from_below;
            default:           data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// File: hdl/i2p_stack.sv
module i2p_stack #(
    parameter int STACK_DEPTH = 32
) (
    input  logic               clk,
    input  i2p_pkg::stk_op_t   op,
    input  i2p_pkg::char_t     push_char,
    output i2p_pkg::char_t     top0,
    output i2p_pkg::char_t     top1
);

    i2p_pkg::char_t cell_data [STACK_DEPTH];

    // Cell 0 is the top; push shifts toward the bottom, pop toward the top.
    for (genvar i = 0; i < STACK_DEPTH; i++)
    begin : g_cell
        i2p_pkg::char_t above;
        i2p_pkg::char_t below;

        if (i == 0)
        begin : g_top
            assign above = push_char;
        end
        else
        begin : g_mid
            assign above = cell_data[i-1];
        end

        if (i == STACK_DEPTH - 1)
        begin : g_bot
            assign below = '0;
        end
        else
        begin : g_nbot
            assign below = cell_data[i+1];
        end

        i2p_cell u_cell (
            .clk        (clk),
            .op         (op),
            .from_above (above),
            .from_below (below),
            .data       (cell_data[i])
        );
    end

    assign top0 = cell_data[0];
    assign top1 = cell_data[1];

endmodule

// File: hdl/infix_to_postfix_converter_top.sv
// Channel | Handshake           | Payload
// --------+---------------------+-------------------------------------------------
// in      | in_valid, in_ready  | in_char, in_last
// out     | out_valid, out_ready| char_valid, out_char, run_last, expr_end, error_code
//
// One request is taken, then handled one stack step per cycle by the sequencer
// while the output slot is free: the accept, then a step per emitted char, pop or
// push; a further step when ')' or the drain finds the stack empty (the drain's
// check carries an empty result when nothing was emitted), and a step for an empty
// result outside the drain. An operator is pushed at its own request, popped later.
// Output stalls hold the sequencer; nothing is taken until the request is done.
// rst_n clears control state and the stack count; stack cells have no reset.
module infix_to_postfix_converter_top #(
    parameter int STACK_DEPTH = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_char,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       char_valid,
    output logic [7:0] out_char,
    output logic       run_last,
    output logic       expr_end,
    output logic [1:0] error_code
);

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_HEAD  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_TAIL  = 2'd3;

    logic [1:0]         state_reg, state_next;
    i2p_pkg::char_t     char_reg, char_next;
    logic               last_reg, last_next;
    i2p_pkg::err_t      err_reg, err_next;
    logic               any_reg, any_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    logic               out_valid_reg, out_valid_next;
    logic               cvalid_reg, cvalid_next;
    i2p_pkg::char_t     ochar_reg, ochar_next;
    logic               rlast_reg, rlast_next;
    logic               xend_reg, xend_next;
    i2p_pkg::err_t      ecode_reg, ecode_next;

    i2p_pkg::stk_op_t   stk_op;
    i2p_pkg::char_t     top0, top1;

    logic slot_free;
    logic cnt_zero, cnt_one, cnt_two, full;
    logic in_acc;

    assign slot_free = !out_valid_reg || out_ready;
    assign cnt_zero  = (count_reg == '0);
    assign cnt_one   = (count_reg == CNT_W'(1));
    assign cnt_two   = (count_reg == CNT_W'(2));
    assign full      = (count_reg == CNT_W'(STACK_DEPTH));
    assign in_ready  = (state_reg == S_IDLE);
    assign in_acc    = in_valid && in_ready;

    i2p_stack #(.STACK_DEPTH(STACK_DEPTH)) u_stack (
        .clk       (clk),
        .op        (stk_op),
        .push_char (char_reg),
        .top0      (top0),
        .top1      (top1)
    );

    always_comb
    begin
        logic emit;
        logic fin;
        i2p_pkg::prec_t p;

        state_next  = state_reg;
        char_next   = char_reg;
        last_next   = last_reg;
        err_next    = err_reg;
        any_next    = any_reg;
        count_next  = count_reg;
        stk_op      = i2p_pkg::STK_HOLD;
        emit        = 1'b0;
        fin         = 1'b0;
        p           = i2p_pkg::prec_of(char_reg);
        cvalid_next = 1'b1;
        ochar_next  = top0;
        rlast_next  = 1'b0;
        xend_next   = 1'b0;
        ecode_next  = i2p_pkg::ERR_NONE;

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    char_next  = in_char;
                    last_next  = in_last;
                    err_next   = i2p_pkg::ERR_NONE;
                    any_next   = 1'b0;
                    state_next = S_HEAD;
                end
            end
            S_HEAD:
            begin
                if (slot_free)
                begin
                    if (!(char_reg inside {i2p_pkg::CH_MUL, i2p_pkg::CH_DIV, i2p_pkg::CH_MOD,
                                           i2p_pkg::CH_ADD, i2p_pkg::CH_SUB,
                                           i2p_pkg::CH_LPAREN, i2p_pkg::CH_RPAREN}))
                    begin
                        emit       = 1'b1;
                        fin        = !last_reg || cnt_zero;
                        ochar_next = char_reg;
                        xend_next  = last_reg;
                        any_next   = 1'b1;
                        state_next = fin ? S_IDLE : S_DRAIN;
                    end
                    else if (char_reg == i2p_pkg::CH_RPAREN)
                    begin
                        if (cnt_zero)
                        begin
                            err_next   = i2p_pkg::ERR_UNMATCH;
                            state_next = last_reg ? S_DRAIN : (any_reg ? S_IDLE : S_TAIL);
                        end
                        else if (top0 == i2p_pkg::CH_LPAREN)
                        begin
                            stk_op     = i2p_pkg::STK_POP;
                            count_next = count_reg - CNT_W'(1);
                            state_next = last_reg ? S_DRAIN : S_IDLE;
                        end
                        else
                        begin
                            // look one cell ahead so the final result is marked now
                            stk_op     = i2p_pkg::STK_POP;
                            count_next = count_reg - CNT_W'(1);
                            emit       = 1'b1;
                            any_next   = 1'b1;
                            fin        = cnt_one ||
                                         (top1 == i2p_pkg::CH_LPAREN && (!last_reg || cnt_two));
                            xend_next  = last_reg && fin;
                            ecode_next = cnt_one ? i2p_pkg::ERR_UNMATCH : i2p_pkg::ERR_NONE;
                        end
                    end
                    else if (char_reg != i2p_pkg::CH_LPAREN && !cnt_zero &&
                             i2p_pkg::prec_of(top0) >= p)
                    begin
                        stk_op     = i2p_pkg::STK_POP;
                        count_next = count_reg - CNT_W'(1);
                        emit       = 1'b1;
                        any_next   = 1'b1;
                        fin        = !last_reg && !(!cnt_one && i2p_pkg::prec_of(top1) >= p);
                    end
                    else
                    begin
                        // push of '(' or of an operator once its pops are done; overflow if full
                        if (full)
                        begin
                            err_next = i2p_pkg::ERR_OVERFLOW;
                        end
                        else
                        begin
                            stk_op     = i2p_pkg::STK_PUSH;
                            count_next = count_reg + CNT_W'(1);
                        end
                        state_next = last_reg ? S_DRAIN : (full ? S_TAIL : S_IDLE);
                    end
                end
            end
            S_DRAIN:
            begin
                if (slot_free)
                begin
                    if (cnt_zero)
                    begin
                        emit        = !any_reg;
                        fin         = 1'b1;
                        cvalid_next = 1'b0;
                        ochar_next  = '0;
                        xend_next   = 1'b1;
                        ecode_next  = err_reg;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        stk_op     = i2p_pkg::STK_POP;
                        count_next = count_reg - CNT_W'(1);
                        emit       = 1'b1;
                        any_next   = 1'b1;
                        fin        = cnt_one;
                        xend_next  = cnt_one;
                        ecode_next = cnt_one ? err_reg : i2p_pkg::ERR_NONE;
                    end
                end
            end
            S_TAIL:
            begin
                if (slot_free)
                begin
                    emit        = 1'b1;
                    fin         = 1'b1;
                    cvalid_next = 1'b0;
                    ochar_next  = '0;
                    ecode_next  = err_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        rlast_next = fin;
        if (!fin)
        begin
            xend_next  = 1'b0;
            ecode_next = i2p_pkg::ERR_NONE;
        end

        out_valid_next = out_valid_reg;
        if (slot_free)
        begin
            out_valid_next = emit;
        end
        if (!(slot_free && emit))
        begin
            cvalid_next = cvalid_reg;
            ochar_next  = ochar_reg;
            rlast_next  = rlast_reg;
            xend_next   = xend_reg;
            ecode_next  = ecode_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            err_reg       <= i2p_pkg::ERR_NONE;
            any_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            err_reg       <= err_next;
            any_reg       <= any_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg   <= char_next;
        last_reg   <= last_next;
        cvalid_reg <= cvalid_next;
        ochar_reg  <= ochar_next;
        rlast_reg  <= rlast_next;
        xend_reg   <= xend_next;
        ecode_reg  <= ecode_next;
    end

    assign out_valid  = out_valid_reg;
    assign char_valid = cvalid_reg;
    assign out_char   = ochar_reg;
    assign run_last   = rlast_reg;
    assign expr_end   = xend_reg;
    assign error_code = ecode_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_empty_is_final: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !char_valid) |-> run_last)
        else $error("empty result not final");

    a_status_on_final: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !run_last) |-> (error_code == i2p_pkg::ERR_NONE && !expr_end))
        else $error("status on non-final result");

    a_accept_keeps_stack: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> $stable(count_reg))
        else $error("stack moved on accept");

endmodule
